### sv/utg7_pkg.sv
// ============================================================================
// utg7_pkg
// Shared types, constants and the code point to GSM 7-bit alphabet mapping
// used by the UTF-8 to GSM 7-bit converter.
// ============================================================================
package utg7_pkg;

  // Code unit constants.
  localparam logic [6:0] GSM_ESCAPE  = 7'h1B;
  localparam logic [6:0] GSM_UNKNOWN = 7'h3F;

  // Width of the count of continuation bytes still expected for a code point.
  localparam int unsigned PEND_W = 2;

  // Width of an assembled code point.
  localparam int unsigned CP_W = 21;

  // Result of mapping one code point: one code unit, or an escape pair.
  typedef struct packed {
    logic       two;
    logic [6:0] code0;
    logic [6:0] code1;
  } utg7_map_t;

  // One decoded item as it leaves the decoder: zero, one or two code units,
  // plus the message status when the byte was the last of its message.
  typedef struct packed {
    logic       emit;
    logic       has_code;
    logic       two;
    logic [6:0] code0;
    logic [6:0] code1;
    logic       last;
    logic       msg_valid;
  } utg7_item_t;

  // Map a code point to the default alphabet. The direct ASCII ranges come
  // first, then the default table, then the extension table, else '?'.
  function automatic utg7_map_t utg7_map(input logic [CP_W-1:0] cp);
    utg7_map_t m;
    m.two   = 1'b0;
    m.code0 = GSM_UNKNOWN;
    m.code1 = '0;
    if ((cp >= 21'd32 && cp <= 21'd35) || (cp >= 21'd37 && cp <= 21'd63) ||
        (cp >= 21'd65 && cp <= 21'd90) || (cp >= 21'd97 && cp <= 21'd122)) begin
      m.code0 = cp[6:0];
    end else begin
      case (cp)
        // Default table entries outside the direct ranges.
        21'h000040: m.code0 = 7'd0;
        21'h0000A3: m.code0 = 7'd1;
        21'h000024: m.code0 = 7'd2;
        21'h0000A5: m.code0 = 7'd3;
        21'h0000E8: m.code0 = 7'd4;
        21'h0000E9: m.code0 = 7'd5;
        21'h0000F9: m.code0 = 7'd6;
        21'h0000EC: m.code0 = 7'd7;
        21'h0000F2: m.code0 = 7'd8;
        21'h0000E7: m.code0 = 7'd9;
        21'h00000A: m.code0 = 7'd10;
        21'h0000D8: m.code0 = 7'd11;
        21'h0000F8: m.code0 = 7'd12;
        21'h00000D: m.code0 = 7'd13;
        21'h0000C5: m.code0 = 7'd14;
        21'h0000E5: m.code0 = 7'd15;
        21'h000394: m.code0 = 7'd16;
        21'h00005F: m.code0 = 7'd17;
        21'h0003A6: m.code0 = 7'd18;
        21'h000393: m.code0 = 7'd19;
        21'h00039B: m.code0 = 7'd20;
        21'h0003A9: m.code0 = 7'd21;
        21'h0003A0: m.code0 = 7'd22;
        21'h0003A8: m.code0 = 7'd23;
        21'h0003A3: m.code0 = 7'd24;
        21'h000398: m.code0 = 7'd25;
        21'h00039E: m.code0 = 7'd26;
        21'h0000A0: m.code0 = 7'd27;
        21'h0000C6: m.code0 = 7'd28;
        21'h0000E6: m.code0 = 7'd29;
        21'h0000DF: m.code0 = 7'd30;
        21'h0000C9: m.code0 = 7'd31;
        21'h0000A4: m.code0 = 7'd36;
        21'h0000A1: m.code0 = 7'd64;
        21'h0000C4: m.code0 = 7'd91;
        21'h0000D6: m.code0 = 7'd92;
        21'h0000D1: m.code0 = 7'd93;
        21'h0000DC: m.code0 = 7'd94;
        21'h0000A7: m.code0 = 7'd95;
        21'h0000BF: m.code0 = 7'd96;
        21'h0000E4: m.code0 = 7'd123;
        21'h0000F6: m.code0 = 7'd124;
        21'h0000F1: m.code0 = 7'd125;
        21'h0000FC: m.code0 = 7'd126;
        21'h0000E0: m.code0 = 7'd127;
        // Extension table: escape followed by the extension code.
        21'h00000C: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h0A; end
        21'h00005E: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h14; end
        21'h00007B: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h28; end
        21'h00007D: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h29; end
        21'h00005C: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h2F; end
        21'h00005B: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h3C; end
        21'h00007E: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h3D; end
        21'h00005D: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h3E; end
        21'h00007C: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h40; end
        21'h0020AC: begin m.two = 1'b1; m.code0 = GSM_ESCAPE; m.code1 = 7'h65; end
        default:    m.code0 = GSM_UNKNOWN;
      endcase
    end
    return m;
  endfunction

endpackage

### sv/utg7_decoder.sv
// ============================================================================
// utg7_decoder
// Assembles UTF-8 code points byte by byte, tracks message validity and
// maps each finished code point to GSM 7-bit code units.
// ============================================================================
module utg7_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         in_byte,
  input  logic               last_byte,
  output utg7_pkg::utg7_item_t item
);
  import utg7_pkg::*;

  logic [CP_W-1:0]   code_accum;
  logic [CP_W-1:0]   code_accum_next;
  logic [PEND_W-1:0] bytes_pending;
  logic [PEND_W-1:0] bytes_pending_next;
  logic              valid_so_far;
  logic              valid_next;

  logic              is_cont;
  logic [CP_W-1:0]   cont_point;
  logic [CP_W-1:0]   map_point;
  logic              map_en;
  utg7_map_t         mapped;

  // Next assembly state and the code point, if any, finished by this byte.
  always_comb begin
    code_accum_next    = code_accum;
    bytes_pending_next = bytes_pending;
    valid_next         = valid_so_far;
    map_en             = 1'b0;
    map_point          = {{(CP_W-8){1'b0}}, in_byte};
    is_cont            = (in_byte[7:6] == 2'b10);
    cont_point         = {code_accum[CP_W-7:0], in_byte[5:0]};

    if (bytes_pending != '0 && is_cont) begin
      // A good continuation byte extends the pending code point.
      bytes_pending_next = bytes_pending - 1'b1;
      code_accum_next    = cont_point;
      if (bytes_pending == PEND_W'(1)) begin
        map_en          = 1'b1;
        map_point       = cont_point;
        code_accum_next = '0;
      end
    end else begin
      // A bad continuation drops the sequence; the byte is then a new lead.
      if (bytes_pending != '0) begin
        valid_next = 1'b0;
      end
      bytes_pending_next = '0;
      code_accum_next    = '0;
      if ((in_byte >= 8'h80 && in_byte <= 8'hC1) || in_byte >= 8'hF5) begin
        valid_next = 1'b0;
      end else if (!in_byte[7]) begin
        map_en = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        code_accum_next    = {{(CP_W-5){1'b0}}, in_byte[4:0]};
        bytes_pending_next = PEND_W'(1);
      end else if (in_byte[7:4] == 4'b1110) begin
        code_accum_next    = {{(CP_W-4){1'b0}}, in_byte[3:0]};
        bytes_pending_next = PEND_W'(2);
      end else begin
        code_accum_next    = {{(CP_W-3){1'b0}}, in_byte[2:0]};
        bytes_pending_next = PEND_W'(3);
      end
    end

    // A message that ends inside a sequence is truncated.
    if (last_byte && bytes_pending_next != '0) begin
      valid_next = 1'b0;
    end
  end

  assign mapped = utg7_map(map_point);

  // Decoded item presented to the result stage.
  always_comb begin
    item.has_code  = map_en;
    item.two       = map_en & mapped.two;
    item.code0     = map_en ? mapped.code0 : '0;
    item.code1     = mapped.code1;
    item.last      = last_byte;
    item.msg_valid = valid_next;
    item.emit      = map_en | last_byte;
  end

  // Assembly state; the end of a message returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_accum    <= '0;
      bytes_pending <= '0;
      valid_so_far  <= 1'b1;
    end else if (take) begin
      if (last_byte) begin
        code_accum    <= '0;
        bytes_pending <= '0;
        valid_so_far  <= 1'b1;
      end else begin
        code_accum    <= code_accum_next;
        bytes_pending <= bytes_pending_next;
        valid_so_far  <= valid_next;
      end
    end
  end

endmodule

### sv/utf8_to_gsm7_converter_top.sv
// The first result of a byte is registered and valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle while out_stall is low; a byte that yields an escape pair holds the
// result register until both of its code units are taken, so the next byte waits.
// Bytes that yield no result are taken without using the output.
// Reset: synchronous, active high; clears assembly state and empties the result register.
// ============================================================================
// utf8_to_gsm7_converter_top
// UTF-8 to GSM 7-bit default alphabet converter: decoder plus result register that presents
// a status-only result or one or two code units per item on the output channel.
// ============================================================================
module utf8_to_gsm7_converter_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] gsm_code,
  output logic       has_code,
  output logic       run_last,
  output logic       message_end,
  output logic       message_valid
);
  import utg7_pkg::*;

  utg7_item_t item;
  utg7_item_t slot;
  logic       slot_full;
  logic       slot_idx;
  logic       slot_done;
  logic       take;

  // The result register frees up when its final result is taken.
  assign slot_done = slot_full && !out_stall && (slot_idx || !slot.two);
  assign in_stall  = slot_full && !slot_done;
  assign take      = in_valid && !in_stall;

  utg7_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (in_byte),
    .last_byte (last_byte),
    .item      (item)
  );

  // Result register and position within an escape pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full <= 1'b0;
      slot_idx  <= 1'b0;
    end else if (take && item.emit) begin
      slot_full <= 1'b1;
      slot_idx  <= 1'b0;
    end else if (slot_done) begin
      slot_full <= 1'b0;
      slot_idx  <= 1'b0;
    end else if (slot_full && !out_stall) begin
      slot_idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.emit) begin
      slot <= item;
    end
  end

  // Output fields for the result at the current position.
  always_comb begin
    out_valid     = slot_full;
    gsm_code      = slot_idx ? slot.code1 : slot.code0;
    has_code      = slot.has_code;
    run_last      = slot_idx || !slot.two;
    message_end   = run_last && slot.last;
    message_valid = message_end && slot.msg_valid;
  end

  // The second position is only ever used by an escape pair.
  a_idx_two: assert property (@(posedge clk) disable iff (rst)
    slot_full && slot_idx |-> slot.two)
    else $error("second result shown for a single-unit item");

  // An escape pair always opens with the escape code.
  a_esc_first: assert property (@(posedge clk) disable iff (rst)
    slot_full && slot.two && !slot_idx |-> slot.code0 == GSM_ESCAPE)
    else $error("escape pair without leading escape");

  // A new item never overwrites a result that is still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    take && item.emit |-> !slot_full || slot_done)
    else $error("result register overwritten");

  // A status-only result is always the end of a message.
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_code |-> message_end && gsm_code == '0)
    else $error("status-only result outside message end");

  // After reset nothing is presented on the output.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule
